// ----- rtl/pdh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared constants, codes and types of the pairwise distance histogram core.
// ----------------------------------------------------------------------------
package pdh_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int MAX_BINS   = 16384;
	localparam int COORD_W    = 24;

	localparam int PT_AW   = $clog2(MAX_POINTS);
	localparam int TALLY_W = PT_AW + 1;
	localparam int BIN_AW  = $clog2(MAX_BINS);
	localparam int BINS_W  = BIN_AW + 1;
	localparam int DIFF_W  = COORD_W;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SQ_W    = PROD_W + 2;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int ITER_W  = $clog2(ROOT_W);
	localparam int CNT_W   = 24;
	localparam int WIDTH_W = 25;

	localparam int BIN_TOTAL_W   = 15;
	localparam int SLICE_FIRST_W = 12;
	localparam int SLICE_END_W   = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_BIN_TOTAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_END   = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_FEW   = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = (a >= b) ? ({a[COORD_W-1], a} - {b[COORD_W-1], b})
			: ({b[COORD_W-1], b} - {a[COORD_W-1], a});
		return d[DIFF_W-1:0];
	endfunction

endpackage

// ----- rtl/pdh_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdh_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdh_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         cmd;
	logic signed [pdh_pkg::COORD_W-1:0] pos_x;
	logic signed [pdh_pkg::COORD_W-1:0] pos_y;
	logic signed [pdh_pkg::COORD_W-1:0] pos_z;
	logic [pdh_pkg::BIN_AW-1:0]         bin_select;

	modport source(output valid, cmd, pos_x, pos_y, pos_z, bin_select, input ready);
	modport sink(input valid, cmd, pos_x, pos_y, pos_z, bin_select, output ready);
endinterface

interface pdh_resp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [pdh_pkg::CNT_W-1:0]   bin_value;
	logic [pdh_pkg::WIDTH_W-1:0] width_value;
	logic [pdh_pkg::TALLY_W-1:0] points_held;

	modport source(output valid, status, bin_value, width_value, points_held, input ready);
	modport sink(input valid, status, bin_value, width_value, points_held, output ready);
endinterface

// ----- rtl/pdh_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdh_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pdh_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pdh_pkg::SQ_W-1:0]     radicand,
	output logic                         done,
	output logic [pdh_pkg::ROOT_W-1:0]   root
);
	import pdh_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [SQ_W-1:0]   rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[SQ_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(ROOT_W - 1);
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q <= {rad_q[SQ_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/pdh_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdh_divider
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdh_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pdh_pkg::ROOT_W-1:0] dividend,
	input  logic [pdh_pkg::ROOT_W-1:0] divisor,
	output logic                       done,
	output logic [pdh_pkg::ROOT_W-1:0] quotient
);
	import pdh_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [ROOT_W-1:0] dvd_q;
	logic [ROOT_W-1:0] dvs_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] quo_q;
	logic [ROOT_W:0]   rem_sh;

	assign rem_sh = {rem_q[ROOT_W-1:0], dvd_q[ROOT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(ROOT_W - 1);
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[ROOT_W-2:0], 1'b0};
				if (rem_sh >= {1'b0, dvs_q}) begin
					rem_q <= rem_sh - {1'b0, dvs_q};
					quo_q <= {quo_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[ROOT_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/pairwise_distance_histogram_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_distance_histogram_core
// Point loads are answered straight from idle; reads pass a memory read state.
// After reset the block sweeps its 16384-entry histogram memory to zero, one
// entry a cycle, before it takes any request. A run first repeats that sweep,
// then derives the bin width, then takes each source/target pair in turn; each
// source point first passes a read and a load state. Every pair passes
// through one shared multiplier (three axes), then the iterative square-root
// unit and the iterative divider, each settling one bit a cycle, followed by
// a read-modify-write of the histogram memory. No request is taken while a
// run is busy.
// ----------------------------------------------------------------------------
module pairwise_distance_histogram_core (
	input  logic                           clk,
	input  logic                           arst_n,
	pdh_req_if.sink                        req,
	pdh_resp_if.source                     resp,
	input  logic                           cfg_we,
	input  logic [pdh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdh_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_CLEAR  = 13'b0000000000010,
		S_MUL    = 13'b0000000000100,
		S_SQRT   = 13'b0000000001000,
		S_DIV    = 13'b0000000010000,
		S_SRC_RD = 13'b0000000100000,
		S_SRC_LD = 13'b0000001000000,
		S_PAIR   = 13'b0000010000000,
		S_FETCH  = 13'b0000100000000,
		S_BIN_RD = 13'b0001000000000,
		S_BIN_WR = 13'b0010000000000,
		S_READ   = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [BIN_TOTAL_W-1:0]   bin_total_q;
	logic [SLICE_FIRST_W-1:0] slice_first_q;
	logic [SLICE_END_W-1:0]   slice_end_q;

	logic [TALLY_W-1:0] tally_q;
	logic [WIDTH_W-1:0] width_q;
	point_t             lo_q;
	point_t             hi_q;
	point_t             pi_q;
	logic               run_q;
	logic               diag_q;
	status_t            run_status_q;
	logic [BIN_AW-1:0]  clr_q;
	logic [2:0]         step_q;
	logic [TALLY_W-1:0] i_q;
	logic [TALLY_W-1:0] j_q;
	logic [DIFF_W-1:0]  diff_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SQ_W-1:0]    sum_q;
	logic [BIN_AW-1:0]  bin_addr_q;

	logic               out_v_q;
	status_t            out_status_q;
	logic [CNT_W-1:0]   out_bin_q;
	logic [WIDTH_W-1:0] out_width_q;
	logic [TALLY_W-1:0] out_pts_q;

	point_t             pt_mem [MAX_POINTS];
	point_t             pt_rd_q;
	logic               pt_we;
	logic [PT_AW-1:0]   pt_raddr;
	logic [CNT_W-1:0]   bin_mem [MAX_BINS];
	logic [CNT_W-1:0]   bin_rd_q;
	logic               bin_we;
	logic [BIN_AW-1:0]  bin_waddr;
	logic [BIN_AW-1:0]  bin_raddr;
	logic [CNT_W-1:0]   bin_wdata;

	logic               accept;
	logic [BINS_W-1:0]  eff_bins;
	logic [BIN_AW-1:0]  max_bin;
	logic [TALLY_W-1:0] slice_stop;
	logic [BIN_AW-1:0]  quot_bin;
	point_t             new_pt;
	logic signed [COORD_W-1:0] op_a;
	logic signed [COORD_W-1:0] op_b;

	logic               sqrt_start;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  root;
	logic               div_start;
	logic               div_done;
	logic [ROOT_W-1:0]  div_divisor;
	logic [ROOT_W-1:0]  quot;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_total_q   <= BIN_TOTAL_W'(16);
			slice_first_q <= '0;
			slice_end_q   <= SLICE_END_W'(MAX_POINTS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIN_TOTAL:   bin_total_q   <= cfg_data[BIN_TOTAL_W-1:0];
				CFG_SLICE_FIRST: slice_first_q <= cfg_data[SLICE_FIRST_W-1:0];
				CFG_SLICE_END:   slice_end_q   <= cfg_data[SLICE_END_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bin_total_q < BIN_TOTAL_W'(2)) begin
			eff_bins = BINS_W'(2);
		end else if (bin_total_q > BIN_TOTAL_W'(MAX_BINS)) begin
			eff_bins = BINS_W'(MAX_BINS);
		end else begin
			eff_bins = BINS_W'(bin_total_q);
		end
	end

	assign max_bin    = BIN_AW'(eff_bins - 1'b1);
	assign slice_stop = (TALLY_W'(slice_end_q) < tally_q) ? TALLY_W'(slice_end_q) : tally_q;
	assign quot_bin   = (quot > ROOT_W'(max_bin)) ? max_bin : quot[BIN_AW-1:0];

	assign req.ready = (state_q == S_IDLE) && (!out_v_q || resp.ready);
	assign accept    = req.valid && req.ready;

	assign new_pt.x = req.pos_x;
	assign new_pt.y = req.pos_y;
	assign new_pt.z = req.pos_z;

	// axis operands for the shared multiplier
	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin
				op_a = diag_q ? hi_q.x : pi_q.x;
				op_b = diag_q ? lo_q.x : pt_rd_q.x;
			end
			2'd1: begin
				op_a = diag_q ? hi_q.y : pi_q.y;
				op_b = diag_q ? lo_q.y : pt_rd_q.y;
			end
			default: begin
				op_a = diag_q ? hi_q.z : pi_q.z;
				op_b = diag_q ? lo_q.z : pt_rd_q.z;
			end
		endcase
	end

	assign sqrt_start  = (state_q == S_MUL) && (step_q == 3'd5);
	assign div_start   = (state_q == S_SQRT) && sqrt_done;
	assign div_divisor = diag_q ? ROOT_W'(eff_bins) : ROOT_W'(width_q);

	pdh_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (root)
	);

	pdh_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (root),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// memories
	assign pt_we    = accept && (req.cmd == CMD_LOAD) && (tally_q < TALLY_W'(MAX_POINTS));
	assign pt_raddr = (state_q == S_SRC_RD) ? i_q[PT_AW-1:0] : j_q[PT_AW-1:0];

	assign bin_we    = (state_q == S_CLEAR) || (state_q == S_BIN_WR);
	assign bin_waddr = (state_q == S_CLEAR) ? clr_q : bin_addr_q;
	assign bin_wdata = (state_q == S_CLEAR) ? '0
		: ((bin_rd_q == {CNT_W{1'b1}}) ? bin_rd_q : bin_rd_q + 1'b1);
	assign bin_raddr = (state_q == S_BIN_RD) ? quot_bin : req.bin_select;

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[tally_q[PT_AW-1:0]] <= new_pt;
		end
		pt_rd_q <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[bin_waddr] <= bin_wdata;
		end
		bin_rd_q <= bin_mem[bin_raddr];
	end

	// squared distance accumulation
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			if (step_q < 3'd3) begin
				diff_q <= abs_diff(op_a, op_b);
			end
			if (step_q >= 3'd1 && step_q <= 3'd3) begin
				prod_q <= diff_q * diff_q;
			end
			if (step_q >= 3'd2 && step_q <= 3'd4) begin
				sum_q <= sum_q + SQ_W'(prod_q);
			end
		end else begin
			sum_q <= '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			run_q        <= 1'b0;
			diag_q       <= 1'b0;
			run_status_q <= ST_OK;
			clr_q        <= '0;
			step_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			tally_q      <= '0;
			width_q      <= '0;
			bin_addr_q   <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			pi_q         <= '0;
			out_v_q      <= 1'b0;
			out_status_q <= ST_OK;
			out_bin_q    <= '0;
			out_width_q  <= '0;
			out_pts_q    <= '0;
		end else begin
			if (out_v_q && resp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							CMD_LOAD: begin
								out_v_q     <= 1'b1;
								out_bin_q   <= '0;
								out_width_q <= width_q;
								if (tally_q >= TALLY_W'(MAX_POINTS)) begin
									out_status_q <= ST_FULL;
									out_pts_q    <= tally_q;
								end else begin
									out_status_q <= ST_OK;
									out_pts_q    <= tally_q + 1'b1;
									tally_q      <= tally_q + 1'b1;
									if (tally_q == '0) begin
										lo_q <= new_pt;
										hi_q <= new_pt;
									end else begin
										if (new_pt.x < lo_q.x) lo_q.x <= new_pt.x;
										if (new_pt.y < lo_q.y) lo_q.y <= new_pt.y;
										if (new_pt.z < lo_q.z) lo_q.z <= new_pt.z;
										if (new_pt.x > hi_q.x) hi_q.x <= new_pt.x;
										if (new_pt.y > hi_q.y) hi_q.y <= new_pt.y;
										if (new_pt.z > hi_q.z) hi_q.z <= new_pt.z;
									end
								end
							end
							CMD_RUN: begin
								run_q        <= 1'b1;
								run_status_q <= ST_OK;
								clr_q        <= '0;
								state_q      <= S_CLEAR;
							end
							CMD_READ: begin
								if (BINS_W'(req.bin_select) >= eff_bins) begin
									out_v_q      <= 1'b1;
									out_status_q <= ST_RANGE;
									out_bin_q    <= '0;
									out_width_q  <= width_q;
									out_pts_q    <= tally_q;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								tally_q      <= '0;
								out_v_q      <= 1'b1;
								out_status_q <= ST_OK;
								out_bin_q    <= '0;
								out_width_q  <= width_q;
								out_pts_q    <= '0;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_AW'(MAX_BINS - 1)) begin
						if (!run_q) begin
							state_q <= S_IDLE;
						end else if (tally_q < TALLY_W'(2)) begin
							width_q      <= '0;
							run_status_q <= ST_FEW;
							state_q      <= S_DONE;
						end else begin
							diag_q  <= 1'b1;
							step_q  <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (diag_q) begin
							diag_q  <= 1'b0;
							width_q <= (quot == '0) ? WIDTH_W'(1) : WIDTH_W'(quot);
							if (TALLY_W'(slice_first_q) >= slice_stop) begin
								state_q <= S_DONE;
							end else begin
								i_q     <= TALLY_W'(slice_first_q);
								state_q <= S_SRC_RD;
							end
						end else begin
							state_q <= S_BIN_RD;
						end
					end
				end
				S_SRC_RD: begin
					state_q <= S_SRC_LD;
				end
				S_SRC_LD: begin
					pi_q    <= pt_rd_q;
					j_q     <= '0;
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					if (j_q == tally_q) begin
						if (i_q + 1'b1 >= slice_stop) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SRC_RD;
						end
					end else if (j_q == i_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_BIN_RD: begin
					bin_addr_q <= quot_bin;
					state_q    <= S_BIN_WR;
				end
				S_BIN_WR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_PAIR;
				end
				S_READ: begin
					out_v_q      <= 1'b1;
					out_status_q <= ST_OK;
					out_bin_q    <= bin_rd_q;
					out_width_q  <= width_q;
					out_pts_q    <= tally_q;
					state_q      <= S_IDLE;
				end
				default: begin
					out_v_q      <= 1'b1;
					out_status_q <= run_status_q;
					out_bin_q    <= '0;
					out_width_q  <= width_q;
					out_pts_q    <= tally_q;
					run_q        <= 1'b0;
					state_q      <= S_IDLE;
				end
			endcase
		end
	end

	assign resp.valid       = out_v_q;
	assign resp.status      = out_status_q;
	assign resp.bin_value   = out_bin_q;
	assign resp.width_value = out_width_q;
	assign resp.points_held = out_pts_q;

`ifndef SYNTHESIS
	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_W'(MAX_POINTS))
		else $error("point count above store depth");

	a_pair_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> (j_q < tally_q && j_q != i_q))
		else $error("target index out of range or equal to source");

	a_bin_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BIN_WR |-> bin_addr_q <= max_bin)
		else $error("bin index beyond bins in use");

	a_width_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRC_RD |-> width_q != '0)
		else $error("pair loop started with zero bin width");
`endif

endmodule

// ----- sim/tb_pairwise_distance_histogram_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_distance_histogram_core
// Self-checking bench for the pairwise distance histogram core. A directed
// table covers reset values, coordinate extremes, too-few-point runs, zero
// distances and out-of-range reads. It is followed by random load/run/read
// sequences under several bin and slice settings.
// Every response is checked against a behavioral histogram predictor or, for
// typed directed rows, their expected value. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_pairwise_distance_histogram_core;
	import pdh_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct {
		logic [1:0]         status;
		logic [CNT_W-1:0]   bin_value;
		logic [WIDTH_W-1:0] width_value;
		logic [TALLY_W-1:0] points_held;
	} hist_resp_t;

	typedef struct {
		cmd_t       cmd;
		int         x;
		int         y;
		int         z;
		int         sel;
		bit         typed;
		hist_resp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pdh_req_if req();
	pdh_resp_if resp();

	pairwise_distance_histogram_core uut (
		.clk(clk), .arst_n(arst_n), .req(req), .resp(resp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [COORD_W-1:0] pts [MAX_POINTS][3];
	int unsigned tally;
	int lo [3];
	int hi [3];
	int unsigned counts [MAX_BINS];
	longint unsigned width_q;
	int unsigned bin_total_q, slice_first_q, slice_end_q;

	hist_resp_t pending_results[$];
	int errors, accepted, results_seen, runs_done, idle_cycles;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sq_dist(int a0, int a1, int a2, int b0, int b1, int b2);
		longint d0, d1, d2;
		d0 = longint'(a0) - longint'(b0);
		d1 = longint'(a1) - longint'(b1);
		d2 = longint'(a2) - longint'(b2);
		if (d0 < 0) d0 = -d0;
		if (d1 < 0) d1 = -d1;
		if (d2 < 0) d2 = -d2;
		return longint'(d0 * d0) + longint'(d1 * d1) + longint'(d2 * d2);
	endfunction

	function automatic int unsigned bins_used();
		if (bin_total_q < 2) return 2;
		if (bin_total_q > MAX_BINS) return MAX_BINS;
		return bin_total_q;
	endfunction

	function automatic hist_resp_t histogram_predict(cmd_t cmd, int x, int y, int z, int sel);
		hist_resp_t r;
		int p [3];
		int unsigned nb, last;
		longint unsigned b;
		int s;
		r.status = ST_OK;
		r.bin_value = '0;
		s = sel & 16'h3FFF;
		p[0] = int'($signed(x[COORD_W-1:0]));
		p[1] = int'($signed(y[COORD_W-1:0]));
		p[2] = int'($signed(z[COORD_W-1:0]));
		case (cmd)
			CMD_LOAD: begin
				if (tally >= MAX_POINTS) begin
					r.status = ST_FULL;
				end else begin
					for (int k = 0; k < 3; k++) begin
						pts[tally][k] = p[k];
						if (tally == 0 || p[k] < lo[k]) lo[k] = p[k];
						if (tally == 0 || p[k] > hi[k]) hi[k] = p[k];
					end
					tally++;
				end
			end
			CMD_RUN: begin
				nb = bins_used();
				foreach (counts[i]) counts[i] = 0;
				runs_done++;
				if (tally < 2) begin
					width_q = 0;
					r.status = ST_FEW;
				end else begin
					width_q = isqrt(sq_dist(hi[0], hi[1], hi[2], lo[0], lo[1], lo[2])) / nb;
					if (width_q < 1) width_q = 1;
					last = (slice_end_q < tally) ? slice_end_q : tally;
					for (int unsigned i = slice_first_q; i < last; i++)
						for (int unsigned j = 0; j < tally; j++) begin
							if (i == j) continue;
							b = isqrt(sq_dist(pts[i][0], pts[i][1], pts[i][2],
								pts[j][0], pts[j][1], pts[j][2])) / width_q;
							if (b > nb - 1) b = nb - 1;
							if (counts[b] < 24'hFFFFFF) counts[b]++;
						end
				end
			end
			CMD_READ: begin
				if (s >= bins_used()) r.status = ST_RANGE;
				else r.bin_value = counts[s];
			end
			default: tally = 0;
		endcase
		r.width_value = width_q[WIDTH_W-1:0];
		r.points_held = tally[TALLY_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int u;
		u = $urandom_range(0, 99);
		if (u < 55) return 0;
		if (u < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic send_request(cmd_t cmd, int x, int y, int z, int sel,
		bit typed, hist_resp_t want);
		hist_resp_t p;
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = histogram_predict(cmd, x, y, z, sel);
		pending_results.push_back(typed ? want : p);
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.pos_x <= x[COORD_W-1:0];
		req.pos_y <= y[COORD_W-1:0];
		req.pos_z <= z[COORD_W-1:0];
		req.bin_select <= sel[BIN_AW-1:0];
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic quiesce();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(int bt, int sf, int se);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= CFG_BIN_TOTAL;
		cfg_data <= bt[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_SLICE_FIRST;
		cfg_data <= sf[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_SLICE_END;
		cfg_data <= se[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		bin_total_q = bt & 16'h7FFF;
		slice_first_q = sf & 12'hFFF;
		slice_end_q = se & 13'h1FFF;
	endtask

	function automatic int rand_coord(int span);
		if (span == 0) return int'($signed(24'($urandom())));
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic send_plain(cmd_t cmd, int x, int y, int z, int sel);
		hist_resp_t none;
		none = '{default: '0};
		send_request(cmd, x, y, z, sel, 1'b0, none);
	endtask

	task automatic random_sequence();
		int k, span, reads, base;
		k = $urandom_range(2, 7);
		span = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3000);
		base = rand_coord(0) / 2;
		send_plain(CMD_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0), $urandom());
		for (int i = 0; i < k; i++)
			send_plain(CMD_LOAD, base + rand_coord(span), base + rand_coord(span),
				rand_coord(span), $urandom());
		if ($urandom_range(0, 9) < 6)
			send_plain(CMD_RUN, rand_coord(0), rand_coord(0), rand_coord(0), $urandom());
		reads = $urandom_range(8, 24);
		for (int i = 0; i < reads; i++)
			send_plain(CMD_READ, rand_coord(0), rand_coord(0), rand_coord(0),
				($urandom_range(0, 9) < 8) ? $urandom_range(0, bins_used() - 1) : $urandom());
	endtask

	task automatic random_noise();
		cmd_t c;
		c = cmd_t'($urandom_range(0, 3));
		if (c == CMD_RUN && tally > 8) c = CMD_READ;
		send_plain(c, rand_coord(0), rand_coord(0), rand_coord(0), $urandom());
	endtask

	// response side: random stall pattern, check and watchdog
	int stall_left;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			resp.ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			resp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		hist_resp_t w;
		if (arst_n) begin
			if (req.valid && req.ready) accepted++;
			if (resp.valid && resp.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected response status=%0d", $time, resp.status);
					errors++;
				end else begin
					w = pending_results.pop_front();
					if (resp.status !== w.status || resp.bin_value !== w.bin_value ||
						resp.width_value !== w.width_value ||
						resp.points_held !== w.points_held) begin
						$display("%0t: mismatch expected st=%0d bin=%0d w=%0d pts=%0d",
							$time, w.status, w.bin_value, w.width_value, w.points_held);
						$display("%0t:          actual   st=%0d bin=%0d w=%0d pts=%0d",
							$time, resp.status, resp.bin_value, resp.width_value,
							resp.points_held);
						errors++;
					end
				end
			end
			if ((req.valid && req.ready) || (resp.valid && resp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_pairwise_distance_histogram_core: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	dir_row_t dir_rows[$];

	initial begin
		int phase_cfg [6][3];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BIN_TOTAL;
		cfg_data = '0;
		req.valid = 1'b0;
		req.cmd = CMD_LOAD;
		req.pos_x = '0;
		req.pos_y = '0;
		req.pos_z = '0;
		req.bin_select = '0;
		resp.ready = 1'b0;
		stall_left = 0;
		errors = 0;
		accepted = 0;
		results_seen = 0;
		runs_done = 0;
		idle_cycles = 0;
		tally = 0;
		width_q = 0;
		foreach (counts[i]) counts[i] = 0;
		foreach (lo[k]) begin
			lo[k] = 0;
			hi[k] = 0;
		end
		bin_total_q = 16;
		slice_first_q = 0;
		slice_end_q = 4096;

		dir_rows.push_back('{CMD_READ, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_RUN, 0, 0, 0, 0, 1, '{ST_FEW, 0, 0, 0}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 16, 1, '{ST_RANGE, 0, 0, 0}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 16383, 1, '{ST_RANGE, 0, 0, 0}});
		dir_rows.push_back('{CMD_LOAD, 8388607, 8388607, 8388607, 0, 1, '{ST_OK, 0, 0, 1}});
		dir_rows.push_back('{CMD_RUN, 0, 0, 0, 0, 1, '{ST_FEW, 0, 0, 1}});
		dir_rows.push_back('{CMD_LOAD, -8388608, -8388608, -8388608, 0, 1,
			'{ST_OK, 0, 0, 2}});
		dir_rows.push_back('{CMD_LOAD, 0, 0, 0, 16383, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_LOAD, -1, 1, 5592405, 0, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_RUN, 0, 0, 0, 0, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 0, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 7, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 15, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_CLEAR, 0, 0, 0, 0, 0, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_RUN, 0, 0, 0, 0, 1, '{ST_FEW, 0, 0, 0}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 3, 1, '{ST_OK, 0, 0, 0}});
		dir_rows.push_back('{CMD_LOAD, 5, 5, 5, 0, 1, '{ST_OK, 0, 0, 1}});
		dir_rows.push_back('{CMD_LOAD, 5, 5, 5, 0, 1, '{ST_OK, 0, 0, 2}});
		dir_rows.push_back('{CMD_RUN, 0, 0, 0, 0, 1, '{ST_OK, 0, 1, 2}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 0, 1, '{ST_OK, 2, 1, 2}});
		dir_rows.push_back('{CMD_READ, 0, 0, 0, 1, 1, '{ST_OK, 0, 1, 2}});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
				dir_rows[i].sel, dir_rows[i].typed, dir_rows[i].want);

		phase_cfg = '{'{2, 0, 4096}, '{16384, 0, 1}, '{0, 4095, 4096},
			'{32767, 1, 3}, '{16, 0, 4096}, '{0, 0, 0}};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) set_config($urandom_range(2, 64), $urandom_range(0, 3),
				$urandom_range(1, 8));
			else set_config(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
			for (int n = 0; n < 240; ) begin
				if ($urandom_range(0, 4) == 0) begin
					random_noise();
					n++;
				end else begin
					random_sequence();
					n += 22;
				end
			end
		end

		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d requests, %0d responses, %0d histogram runs",
			accepted, results_seen, runs_done);
		$display("settings swept: bin count 0..32767, slice edges, empty and tiny stores");
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_pairwise_distance_histogram_core: done, clean");
		else
			$display("tb_pairwise_distance_histogram_core: done, errors");
		$finish;
	end

endmodule
